// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== design/rambd_pkg.sv =====
`timescale 1ns / 1ps

package rambd_pkg;

  // Sizes of the benefit table and the value row.
  localparam int MAX_JOBS        = 16;
  localparam int MAX_PROGRAMMERS = 16;
  localparam int BENEFIT_WIDTH   = 16;

  localparam int JOB_W     = 4;
  localparam int CNT_W     = 4;
  localparam int TAB_AW    = JOB_W + CNT_W;
  localparam int TAB_DEPTH = MAX_JOBS * MAX_PROGRAMMERS;

  // Row values never go negative and never exceed 16 times the largest benefit.
  localparam int ROW_W     = 19;
  localparam int ROW_DEPTH = MAX_PROGRAMMERS + 1;
  localparam int ROW_AW    = 5;
  localparam int CAND_W    = ROW_W + 2;

  // Configuration port.
  localparam int CFG_W     = 5;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_JOB_COUNT        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PROGRAMMER_COUNT = 2'd1;
  localparam logic [CFG_W-1:0]     CFG_RESET            = 5'd16;

  // Operands of the shared add and compare unit.
  typedef struct packed {
    logic [ROW_W-1:0]                row_val;
    logic signed [BENEFIT_WIDTH-1:0] benefit;
    logic [ROW_W-1:0]                top;
  } alu_op_t;

  // Sequencer states.
  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_CLEAR = 9'b000000010,
    S_TOP   = 9'b000000100,
    S_LOAD  = 9'b000001000,
    S_RD    = 9'b000010000,
    S_ACC   = 9'b000100000,
    S_WR    = 9'b001000000,
    S_FIN   = 9'b010000000,
    S_FINW  = 9'b100000000
  } state_t;

endpackage

// ===== design/rambd_alu.sv =====
`timescale 1ns / 1ps

module rambd_alu (
  input  rambd_pkg::alu_op_t            op,
  output logic [rambd_pkg::ROW_W-1:0]   top_out
);
  import rambd_pkg::*;

  logic signed [CAND_W-1:0] cand;
  logic signed [CAND_W-1:0] top_ext;

  // Candidate value: earlier row entry plus this job's benefit.
  assign cand    = $signed({2'b00, op.row_val}) + CAND_W'(op.benefit);
  assign top_ext = $signed({2'b00, op.top});

  // Keep the larger of candidate and running best.
  assign top_out = (cand > top_ext) ? cand[ROW_W-1:0] : op.top;

endmodule

// ===== design/resource_allocation_max_benefit.sv =====
`timescale 1ns / 1ps

// Resource allocation by dynamic programming.
// The input channel loads a benefit table one transfer per cycle while in_ready
// is high: entry (job_index, count_index) is the benefit of giving that job
// count_index+1 programmers. A transfer with last_entry set stores its entry and
// starts the computation; in_ready stays low until the run has finished, while
// transfers without last_entry leave it high.
// The run clears the value row, then for each of J jobs and each programmer
// count p from P down to 1 adds each row entry p-c to the job's benefit for c
// programmers (c from 1 to p) on one shared add and compare unit fed by the
// registered reads of the table and row memories, and writes the best into entry p.
// The result sits in an output register; a stalled receiver holds the block
// at the end of the next run until the waiting result has been taken; table
// loads continue only while the block is idle. The configuration channel is
// always ready and takes job_count (index 0) and programmer_count (index 1);
// both reset to 16. Reset returns the sequencer to idle and drops out_valid;
// the table keeps its contents, which are undefined until written.
module resource_allocation_max_benefit (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [rambd_pkg::JOB_W-1:0]            in_job_index,
  input  logic [rambd_pkg::CNT_W-1:0]            in_count_index,
  input  logic signed [rambd_pkg::BENEFIT_WIDTH-1:0] in_benefit,
  input  logic                                   in_last_entry,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [rambd_pkg::ROW_W-1:0]            out_max_benefit,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [rambd_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [rambd_pkg::CFG_W-1:0]            cfg_data
);
  import rambd_pkg::*;

  state_t                state_r, state_nxt;
  logic [CFG_W-1:0]      job_count_r, prog_count_r;
  logic [CFG_W-1:0]      jobs, progs;
  logic [ROW_AW-1:0]     k_r, k_nxt;
  logic [ROW_AW-1:0]     p_r, p_nxt;
  logic [ROW_AW-1:0]     c_r, c_nxt;
  logic [CFG_W-1:0]      j_r, j_nxt;
  logic [ROW_W-1:0]      top_r, top_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [ROW_W-1:0]      out_data_r, out_data_nxt;
  logic                  in_fire;

  logic signed [BENEFIT_WIDTH-1:0] tab_mem [TAB_DEPTH];
  logic signed [BENEFIT_WIDTH-1:0] tab_q_r;
  logic [TAB_AW-1:0]     tab_raddr;
  logic [ROW_AW-1:0]     c_m1;

  logic [ROW_W-1:0]      row_mem [ROW_DEPTH];
  logic [ROW_W-1:0]      row_q_r;
  logic                  row_we;
  logic [ROW_AW-1:0]     row_waddr, row_raddr;
  logic [ROW_W-1:0]      row_wdata;

  alu_op_t               alu_op;
  logic [ROW_W-1:0]      alu_top;

  assign in_ready        = (state_r == S_IDLE);
  assign in_fire         = in_valid && in_ready;
  assign cfg_ready       = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_max_benefit = out_data_r;

  // Configuration registers, clamped to the table size when used.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_count_r  <= CFG_RESET;
      prog_count_r <= CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_JOB_COUNT:        job_count_r  <= cfg_data;
        REG_PROGRAMMER_COUNT: prog_count_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign jobs  = (job_count_r > CFG_W'(MAX_JOBS)) ? CFG_W'(MAX_JOBS) : job_count_r;
  assign progs = (prog_count_r > CFG_W'(MAX_PROGRAMMERS)) ?
                 CFG_W'(MAX_PROGRAMMERS) : prog_count_r;

  // Benefit table: written by input transfers, read by the sequencer.
  assign c_m1      = c_r - ROW_AW'(1);
  assign tab_raddr = {j_r[JOB_W-1:0], c_m1[CNT_W-1:0]};

  always_ff @(posedge clk) begin
    if (in_fire) begin
      tab_mem[{in_job_index, in_count_index}] <= in_benefit;
    end
    tab_q_r <= tab_mem[tab_raddr];
  end

  // Value row, updated in place from the top programmer count downward.
  always_ff @(posedge clk) begin
    if (row_we) begin
      row_mem[row_waddr] <= row_wdata;
    end
    row_q_r <= row_mem[row_raddr];
  end

  // Shared add and compare unit.
  assign alu_op.row_val = row_q_r;
  assign alu_op.benefit = tab_q_r;
  assign alu_op.top     = top_r;

  rambd_alu u_alu (
    .op      (alu_op),
    .top_out (alu_top)
  );

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    p_nxt         = p_r;
    c_nxt         = c_r;
    j_nxt         = j_r;
    top_nxt       = top_r;
    row_we        = 1'b0;
    row_waddr     = p_r;
    row_wdata     = top_r;
    row_raddr     = p_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire && in_last_entry) begin
          k_nxt     = '0;
          state_nxt = S_CLEAR;
        end
      end
      S_CLEAR: begin
        row_we    = 1'b1;
        row_waddr = k_r;
        row_wdata = '0;
        if (k_r == ROW_AW'(ROW_DEPTH - 1)) begin
          j_nxt = '0;
          p_nxt = progs;
          if (jobs == '0 || progs == '0) begin
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_TOP;
          end
        end else begin
          k_nxt = k_r + ROW_AW'(1);
        end
      end
      S_TOP: begin
        row_raddr = p_r;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        top_nxt   = row_q_r;
        c_nxt     = ROW_AW'(1);
        state_nxt = S_RD;
      end
      S_RD: begin
        row_raddr = p_r - c_r;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        top_nxt = alu_top;
        if (c_r == p_r) begin
          state_nxt = S_WR;
        end else begin
          c_nxt     = c_r + ROW_AW'(1);
          state_nxt = S_RD;
        end
      end
      S_WR: begin
        row_we    = 1'b1;
        row_waddr = p_r;
        row_wdata = top_r;
        if (p_r == ROW_AW'(1)) begin
          if (j_r + CFG_W'(1) == jobs) begin
            state_nxt = S_FIN;
          end else begin
            j_nxt     = j_r + CFG_W'(1);
            p_nxt     = progs;
            state_nxt = S_TOP;
          end
        end else begin
          p_nxt     = p_r - ROW_AW'(1);
          state_nxt = S_TOP;
        end
      end
      S_FIN: begin
        row_raddr = progs;
        state_nxt = S_FINW;
      end
      S_FINW: begin
        row_raddr = progs;
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = row_q_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Counters and datapath registers.
  always_ff @(posedge clk) begin
    k_r        <= k_nxt;
    p_r        <= p_nxt;
    c_r        <= c_nxt;
    j_r        <= j_nxt;
    top_r      <= top_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// ===== design/rambd_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rambd_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          in_last_entry,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [rambd_pkg::ROW_W-1:0]   out_max_benefit,
  input logic                          cfg_ready
);
  import rambd_pkg::*;

  // A stalled result holds its value.
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_max_benefit))

  // A transfer marked last starts a run, so the block is busy next cycle.
  `ASSERT_NEXT(a_last_busy, clk, rst_n, in_valid && in_ready && in_last_entry, !in_ready)

  // Plain table loads keep the input side open.
  `ASSERT_NEXT(a_load_ready, clk, rst_n, in_valid && in_ready && !in_last_entry, in_ready)

  // A new result only appears at the end of a run.
  `ASSERT_SAME(a_result_after_run, clk, rst_n, $rose(out_valid), $past(!in_ready))

  // The configuration channel never stalls.
  `ASSERT_SAME(a_cfg_open, clk, rst_n, 1'b1, cfg_ready)

endmodule

bind resource_allocation_max_benefit rambd_checker u_rambd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .in_last_entry   (in_last_entry),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_max_benefit (out_max_benefit),
  .cfg_ready       (cfg_ready)
);
